// ===== rtl/core/pwtbm_pkg.sv =====
// Shared types, constants and sine table builder for the pulse width tone byte modulator.
`timescale 1ns / 1ps
`default_nettype none
package pwtbm_pkg;

    localparam int unsigned SINE_TABLE_BITS_DEF = 8;
    localparam logic [15:0] UNIT_SAMPLES_RST    = 16'd800;
    localparam logic [14:0] PHASE_STEP_RST      = 15'd3277;

    // Register indexes, taken from byte address bit 2.
    localparam logic REG_UNIT_SAMPLES = 1'b0;
    localparam logic REG_PHASE_STEP   = 1'b1;

    localparam logic [1:0] SEG_IDLE    = 2'd0;
    localparam logic [1:0] SEG_TONE    = 2'd1;
    localparam logic [1:0] SEG_SILENCE = 2'd2;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic [15:0] unit_samples;
        logic [14:0] phase_step;
    } t_cfg;

    typedef struct packed {
        logic signed [6:0] sample;
        logic              byte_taken;
        logic              underrun;
    } t_result;

    typedef struct packed {
        logic [7:0]  shift_byte;
        logic [3:0]  bits_left;
        logic [1:0]  segment;
        logic [17:0] samples_left;
        logic [15:0] tone_phase;
    } t_seq_state;

    // Two Q30 multiplies by the angle, used for one Taylor term.
    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Table entry k: trunc(63.5 * sin(2*pi*k / 2^tbits)), evaluated at elaboration.
    function automatic logic [6:0] sine_entry(input int unsigned k, input int unsigned tbits);
        logic [63:0] half;
        logic [63:0] r;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] mag;
        half = 64'd1 << (tbits - 1);
        r    = 64'(k) & (half - 64'd1);
        m    = (r <= (64'd1 << (tbits - 2))) ? r : (half - r);
        x    = ((m * PI_Q30 * 64'd2) + half) >> tbits;
        sum  = x;
        term = x;
        term = sq_step(term, x) / 64'd6;   sum = sum - term;
        term = sq_step(term, x) / 64'd20;  sum = sum + term;
        term = sq_step(term, x) / 64'd42;  sum = sum - term;
        term = sq_step(term, x) / 64'd72;  sum = sum + term;
        term = sq_step(term, x) / 64'd110; sum = sum - term;
        term = sq_step(term, x) / 64'd156; sum = sum + term;
        term = sq_step(term, x) / 64'd210; sum = sum - term;
        term = sq_step(term, x) / 64'd272; sum = sum + term;
        term = sq_step(term, x) / 64'd342; sum = sum - term;
        mag = (m == 64'd0) ? 64'd0 : ((64'd127 * sum) >> 31);
        if (64'(k) >= half) begin
            mag = 64'd0 - mag;
        end
        return mag[6:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pwtbm_sine_rom.sv =====
// Constant sine lookup table indexed by the top bits of the tone phase.
`timescale 1ns / 1ps
`default_nettype none
module pwtbm_sine_rom #(
    parameter int unsigned SINE_TABLE_BITS = pwtbm_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic [SINE_TABLE_BITS-1:0] i_index,
    output logic signed [6:0]               o_value
);
    import pwtbm_pkg::*;

    localparam int unsigned TAB_SIZE = 1 << SINE_TABLE_BITS;

    logic [6:0] w_rom [TAB_SIZE];

    for (genvar k = 0; k < TAB_SIZE; k++) begin : g_rom
        assign w_rom[k] = sine_entry(k, SINE_TABLE_BITS);
    end

    assign o_value = signed'(w_rom[i_index]);

endmodule
`default_nettype wire

// ===== rtl/core/pwtbm_seq.sv =====
// Symbol sequencer: bit shifter, segment counters, phase accumulator and sample select.
`timescale 1ns / 1ps
`default_nettype none
module pwtbm_seq #(
    parameter int unsigned SINE_TABLE_BITS = pwtbm_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire pwtbm_pkg::t_cfg    i_cfg,
    input  wire logic               i_byte_valid,
    input  wire logic [7:0]         i_byte_value,
    output pwtbm_pkg::t_result      o_result
);
    import pwtbm_pkg::*;

    t_seq_state r_state;
    t_seq_state n_state;
    t_seq_state w_start;
    logic [15:0] w_ulen;
    logic [SINE_TABLE_BITS-1:0] w_rom_index;
    logic signed [6:0] w_rom_value;
    logic w_taken;
    logic w_under;

    // Starts the next data bit or the end marker, or drops back to idle.
    function automatic t_seq_state begin_symbol(input t_seq_state s, input logic [15:0] ulen);
        t_seq_state ns;
        ns = s;
        if (s.bits_left >= 4'd2) begin
            ns.shift_byte   = {s.shift_byte[6:0], 1'b0};
            ns.bits_left    = s.bits_left - 4'd1;
            ns.samples_left = s.shift_byte[7] ? {2'b00, ulen} : {1'b0, ulen, 1'b0};
            ns.segment      = SEG_TONE;
            ns.tone_phase   = '0;
        end else if (s.bits_left == 4'd1) begin
            ns.bits_left    = 4'd0;
            ns.samples_left = {ulen, 2'b00};
            ns.segment      = SEG_TONE;
            ns.tone_phase   = '0;
        end else begin
            ns.segment = SEG_IDLE;
        end
        return ns;
    endfunction

    assign w_ulen = (i_cfg.unit_samples == 16'd0) ? 16'd1 : i_cfg.unit_samples;

    // An idle tick that takes a byte starts its first burst in the same tick.
    always_comb begin
        w_start = r_state;
        w_taken = 1'b0;
        w_under = 1'b0;
        if (r_state.segment == SEG_IDLE) begin
            if (i_byte_valid) begin
                w_start.shift_byte = i_byte_value;
                w_start.bits_left  = 4'd9;
                w_taken            = 1'b1;
                w_start            = begin_symbol(w_start, w_ulen);
            end else begin
                w_under = 1'b1;
            end
        end
    end

    assign w_rom_index = w_start.tone_phase[15 -: SINE_TABLE_BITS];

    pwtbm_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_index (w_rom_index),
        .o_value (w_rom_value)
    );

    always_comb begin
        n_state           = w_start;
        o_result.sample   = '0;
        o_result.byte_taken = w_taken;
        o_result.underrun = w_under;
        unique case (w_start.segment)
            SEG_TONE: begin
                o_result.sample    = w_rom_value;
                n_state.tone_phase = w_start.tone_phase + {1'b0, i_cfg.phase_step};
                if (w_start.samples_left <= 18'd1) begin
                    n_state.segment      = SEG_SILENCE;
                    n_state.samples_left = {2'b00, w_ulen};
                end else begin
                    n_state.samples_left = w_start.samples_left - 18'd1;
                end
            end
            SEG_SILENCE: begin
                if (w_start.samples_left <= 18'd1) begin
                    n_state.samples_left = '0;
                    n_state = begin_symbol(n_state, w_ulen);
                end else begin
                    n_state.samples_left = w_start.samples_left - 18'd1;
                end
            end
            default: begin
                n_state.segment = SEG_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pulse_width_tone_byte_modulator_unit.sv =====
// Pulse width tone byte modulator: one audio sample per tick transfer.
// Usage:
// Each transfer on the slave stream is one sample tick. tuser[0] says a data byte
// is offered and tdata[7:0] carries it. Each tick yields exactly one transfer on the
// master stream: tdata[6:0] is the signed sample, tuser[0] is byte taken and
// tuser[1] is underrun. Bytes go out MSB first as tone bursts of U (one) or 2U (zero)
// samples, each followed by U samples of silence, then a 4U marker and U silence.
// A tick is held in the input register and then moves to the result register, from
// which its result is offered on the master stream.
// Throughput is one tick per cycle while the receiver does not stall: the sequencer
// state, counters and phase accumulator all update in the cycle that moves a tick
// from the input register to the result register.
// When the receiver stalls, the result register holds and the input register still
// takes one more tick; slave tready then drops until the result is taken.
// Synchronous reset returns the sequencer to idle with zero phase and loads the
// default registers (U = 800, phase step = 3277).
// The APB port holds unit_samples at address 0 and phase_step at address 4; the user
// must write it only while no tick is in flight, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none
module pulse_width_tone_byte_modulator_unit #(
    parameter int unsigned SINE_TABLE_BITS = pwtbm_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic [0:0]  s_axis_tuser,   // [0] byte_valid
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [6:0] sample, [7] zero
    output logic [1:0]       m_axis_tuser,   // [0] byte_taken, [1] underrun
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pwtbm_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    r_in_byte_valid;
    logic [7:0] r_in_byte;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_advance;
    logic    w_in_accept;
    logic    w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    // Address bit 2 selects the register; the low bits are the byte offset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_samples <= UNIT_SAMPLES_RST;
            r_cfg.phase_step   <= PHASE_STEP_RST;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_UNIT_SAMPLES: r_cfg.unit_samples <= pwdata[15:0];
                REG_PHASE_STEP:   r_cfg.phase_step   <= pwdata[14:0];
                default:          r_cfg.unit_samples <= r_cfg.unit_samples;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_UNIT_SAMPLES: prdata = {16'd0, r_cfg.unit_samples};
            REG_PHASE_STEP:   prdata = {17'd0, r_cfg.phase_step};
            default:          prdata = '0;
        endcase
    end

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte_valid <= s_axis_tuser[0];
            r_in_byte       <= s_axis_tdata;
        end
    end

    pwtbm_seq #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_cfg        (r_cfg),
        .i_byte_valid (r_in_byte_valid),
        .i_byte_value (r_in_byte),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.sample};
    assign m_axis_tuser  = {r_out.underrun, r_out.byte_taken};

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("byte taken and underrun flagged on the same tick");

    a_underrun_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 8'd0))
        else $error("nonzero sample on an underrun tick");

    a_stall_keeps_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |=> (r_in_valid && r_out_valid))
        else $error("tick dropped while the receiver stalled");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("sequencer step did not produce a result");
`endif

endmodule
`default_nettype wire

// ===== test/pulse_width_tone_byte_modulator_unit_tb.sv =====
// Self-checking testbench for the pulse width tone byte modulator unit.
`timescale 1ns / 1ps
module pulse_width_tone_byte_modulator_unit_tb;
    import pwtbm_pkg::*;

    localparam int unsigned TABLE_BITS = 8;
    localparam int unsigned TABLE_SIZE = 1 << TABLE_BITS;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK} t_rx_mode;

    // Tracks the modulator sequencer and holds the samples still owed by the block.
    class tone_scoreboard;
        logic signed [6:0] sine_rom [TABLE_SIZE];
        logic [15:0] unit_samples;
        logic [14:0] phase_step;
        logic [7:0]  shift_byte;
        logic [3:0]  bits_left;
        logic [1:0]  segment;
        logic [17:0] samples_left;
        logic [15:0] tone_phase;
        t_result     pending_samples [$];
        int          errors;

        function new();
            int unsigned half;
            int unsigned r;
            int unsigned m;
            logic [6:0]  mag;
            half = TABLE_SIZE / 2;
            for (int unsigned k = 0; k < TABLE_SIZE; k++) begin
                r = k % half;
                m = (r <= TABLE_SIZE / 4) ? r : half - r;
                mag = quarter_amplitude(m);
                sine_rom[k] = (k >= half) ? -$signed(mag) : $signed(mag);
            end
            unit_samples = 16'd800;
            phase_step   = 15'd3277;
            shift_byte   = '0;
            bits_left    = '0;
            segment      = SEG_IDLE;
            samples_left = '0;
            tone_phase   = '0;
            errors       = 0;
        endfunction

        // Taylor series of sin in Q30 over the first quadrant, scaled to 63.5.
        function logic [6:0] quarter_amplitude(int unsigned m);
            logic [63:0] ang;
            logic [63:0] term;
            logic [63:0] acc;
            if (m == 0) begin
                return 7'd0;
            end
            ang  = ((64'(m) * PI_Q30 * 64'd2) + 64'(TABLE_SIZE / 2)) >> TABLE_BITS;
            term = ang;
            acc  = ang;
            for (int n = 1; n <= 9; n++) begin
                term = (term * ang) >> 30;
                term = (term * ang) >> 30;
                term = term / (64'(2 * n) * 64'(2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            return 7'((64'd127 * acc) >> 31);
        endfunction

        function logic [17:0] unit_len();
            return (unit_samples == 16'd0) ? 18'd1 : {2'b00, unit_samples};
        endfunction

        function void start_symbol();
            logic [17:0] len;
            if (bits_left >= 4'd2) begin
                len = shift_byte[7] ? unit_len() : 18'd2 * unit_len();
                shift_byte = shift_byte << 1;
                bits_left  = bits_left - 4'd1;
            end else if (bits_left == 4'd1) begin
                bits_left = 4'd0;
                len = 18'd4 * unit_len();
            end else begin
                segment = SEG_IDLE;
                return;
            end
            segment      = SEG_TONE;
            samples_left = len;
            tone_phase   = 16'd0;
        endfunction

        function t_result predict_tick(logic offered, logic [7:0] value);
            t_result r;
            r = '0;
            if (segment == SEG_IDLE) begin
                if (offered) begin
                    shift_byte   = value;
                    bits_left    = 4'd9;
                    r.byte_taken = 1'b1;
                    start_symbol();
                end else begin
                    r.underrun = 1'b1;
                end
            end
            if (segment == SEG_TONE) begin
                r.sample   = sine_rom[tone_phase[15:16-TABLE_BITS]];
                tone_phase = tone_phase + {1'b0, phase_step};
                if (samples_left <= 18'd1) begin
                    segment      = SEG_SILENCE;
                    samples_left = unit_len();
                end else begin
                    samples_left = samples_left - 18'd1;
                end
            end else if (segment == SEG_SILENCE) begin
                if (samples_left <= 18'd1) begin
                    samples_left = 18'd0;
                    start_symbol();
                end else begin
                    samples_left = samples_left - 18'd1;
                end
            end
            return r;
        endfunction

        function void note_tick(logic offered, logic [7:0] value);
            pending_samples.push_back(predict_tick(offered, value));
        endfunction

        task report(string what, int got, int want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_sample(logic signed [6:0] sample, logic taken, logic under);
            t_result want;
            if (pending_samples.size() == 0) begin
                report("unexpected sample transfer", sample, 0);
                return;
            end
            want = pending_samples.pop_front();
            if (sample !== want.sample) begin
                report("sample", sample, want.sample);
            end
            if (taken !== want.byte_taken) begin
                report("byte_taken", taken, want.byte_taken);
            end
            if (under !== want.underrun) begin
                report("underrun", under, want.underrun);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] byte_value
    logic [0:0]  s_axis_tuser = 1'b0;   // [0] byte_valid
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [6:0] sample, [7] zero
    logic [1:0]  m_axis_tuser;          // [0] byte_taken, [1] underrun
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    tone_scoreboard sb = new();
    int unsigned    ticks_taken = 0;
    bit             hold_request = 1'b0;
    bit             brisk = 1'b0;

    pulse_width_tone_byte_modulator_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The input transfer is noted before the output one, so a same-edge result is never early.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_tick(s_axis_tuser[0], s_axis_tdata);
                ticks_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_sample(m_axis_tdata[6:0], m_axis_tuser[0], m_axis_tuser[1]);
            end
        end
    end

    // Receiver: shifting stall patterns or a brisk mostly-ready mode, plus a long hold-off when asked for one.
    initial begin
        t_rx_mode   mode;
        int         span;
        int         hold_left;
        logic [7:0] mask;
        mode = RX_OPEN;
        span = 0;
        hold_left = 0;
        mask = 8'b1011_0010;
        forever begin
            @(negedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_left = 300;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (brisk) begin
                m_axis_tready <= ($urandom_range(0, 7) != 0);
            end else begin
                if (span == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    span = $urandom_range(20, 120);
                    mask = 8'($urandom_range(1, 255));
                end
                span--;
                case (mode)
                    RX_OPEN: begin
                        m_axis_tready <= 1'b1;
                    end
                    RX_COIN: begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                    RX_SPARSE: begin
                        m_axis_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_axis_tready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                endcase
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_tick(logic offered, logic [7:0] value);
        int unsigned seen;
        seen = ticks_taken;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= offered;
        s_axis_tdata  <= value;
        do begin
            @(negedge i_clk);
        end while (ticks_taken == seen);
    endtask

    task automatic run_ticks(int count, int offer_pct);
        int burst;
        int gap;
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && count > 0) begin
                send_tick($urandom_range(0, 99) < offer_pct, pick_byte());
                burst--;
                count--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_samples.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(logic reg_index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == REG_UNIT_SAMPLES) begin
            sb.unit_samples = value[15:0];
        end else begin
            sb.phase_step = value[14:0];
        end
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned unit_list [7];
        int unsigned step_list [7];
        unit_list = '{1, 2, 3, 1, 4, 2, 3};
        step_list = '{1, 0, 3277, 16384, 0, 32767, 0};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero unit length, top phase step, underruns, a busy byte and an idle take.
        write_register(REG_UNIT_SAMPLES, 32'd0);
        write_register(REG_PHASE_STEP, 32'd32767);
        send_tick(1'b0, 8'h00);
        send_tick(1'b0, 8'hFF);
        send_tick(1'b1, 8'hFF);
        repeat (20) send_tick(1'($urandom_range(0, 1)), pick_byte());
        send_tick(1'b1, 8'h00);
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            write_register(REG_UNIT_SAMPLES, unit_list[p]);
            write_register(REG_PHASE_STEP,
                           (step_list[p] == 0) ? $urandom_range(1, 32767) : step_list[p]);
            if (p == 2) begin
                run_ticks(30, 90);
                hold_request = 1'b1;
                run_ticks(100, 90);
            end else begin
                run_ticks(130, (p == 4) ? 40 : 85);
            end
            wait_drained();
        end

        // Long marker: raise U just before the marker segment reads it.
        write_register(REG_UNIT_SAMPLES, 32'd2);
        brisk = 1'b1;
        do begin
            send_tick(1'b1, pick_byte());
        end while (!(sb.bits_left == 4'd1 && sb.segment == SEG_SILENCE));
        wait_drained();
        write_register(REG_UNIT_SAMPLES, 32'd24);
        write_register(REG_PHASE_STEP, $urandom_range(1, 32767));
        do begin
            send_tick(1'($urandom_range(0, 1)), pick_byte());
        end while (sb.segment != SEG_IDLE);
        wait_drained();
        brisk = 1'b0;

        write_register(REG_UNIT_SAMPLES, 32'd1);
        write_register(REG_PHASE_STEP, 32'd3277);
        run_ticks(40, 85);
        wait_drained();
        repeat (10) @(negedge i_clk);

        if (sb.errors == 0) begin
            $display("pulse_width_tone_byte_modulator_unit verification clean");
        end else begin
            $display("pulse_width_tone_byte_modulator_unit verification failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("pulse_width_tone_byte_modulator_unit verification failed");
        $finish;
    end

endmodule
